// File: hdl/two_axis_pid_servo_drive_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-axis PID servo drive
// Shared shorthand for concurrent checks on a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_PID_SERVO_DRIVE_DEFINES_SVH
`define TWO_AXIS_PID_SERVO_DRIVE_DEFINES_SVH

// check that is masked while reset is asserted
`define TAPSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs during reset
`define TAPSD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/tapsd_pkg.sv
// ----------------------------------------------------------------------------
// tapsd_pkg
// Types and constants shared by the two-axis PID servo drive.
// ----------------------------------------------------------------------------
package tapsd_pkg;

    localparam int POSITION_BITS       = 16;
    localparam int GAIN_BITS           = 16;
    localparam int SERVO_BITS          = 8;
    localparam int TILT_BITS           = 6;
    localparam int CFG_IDX_BITS        = 2;

    localparam int INTEGRAL_BITS_DEF   = 32;
    localparam int GAIN_FRAC_BITS_DEF  = 8;

    localparam logic [TILT_BITS-1:0]  TILT_MAX     = 6'd45;
    localparam logic [SERVO_BITS-1:0] SERVO_CENTER = 8'd90;

    localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RST = 16'd26;
    localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RST = 16'd13;

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DERIV_GAIN = 2'd2;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] current_x;
        logic signed [POSITION_BITS-1:0] current_y;
        logic signed [POSITION_BITS-1:0] desired_x;
        logic signed [POSITION_BITS-1:0] desired_y;
    } t_in_item;

    typedef struct packed {
        logic [SERVO_BITS-1:0] servo_left;
        logic [SERVO_BITS-1:0] servo_right;
        logic [SERVO_BITS-1:0] servo_up;
        logic [SERVO_BITS-1:0] servo_down;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_BITS-1:0] prop_gain;
        logic [GAIN_BITS-1:0] integ_gain;
        logic [GAIN_BITS-1:0] deriv_gain;
    } t_gains;

endpackage

// File: hdl/tapsd_axis_state.sv
// ----------------------------------------------------------------------------
// tapsd_axis_state
// Per-axis error, saturating integrator and derivative. The integrator and
// last-error registers are the loop state and also feed the gain stage.
// ----------------------------------------------------------------------------
module tapsd_axis_state
    import tapsd_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic signed [POSITION_BITS-1:0]   i_current,
    input  logic signed [POSITION_BITS-1:0]   i_desired,
    output logic signed [POSITION_BITS:0]     o_err,
    output logic signed [INTEGRAL_BITS-1:0]   o_integral,
    output logic signed [POSITION_BITS+1:0]   o_deriv
);

    localparam int EW = POSITION_BITS + 1;
    localparam int IB = INTEGRAL_BITS;

    localparam logic signed [IB-1:0] IMAX = {1'b0, {(IB-1){1'b1}}};
    localparam logic signed [IB-1:0] IMIN = {1'b1, {(IB-1){1'b0}}};

    logic signed [EW-1:0] r_last_err, n_last_err;
    logic signed [IB-1:0] r_integral, n_integral;
    logic signed [EW:0]   r_deriv, n_deriv;
    logic signed [IB:0]   acc_wide;

    always_comb begin
        n_last_err = EW'(i_desired) - EW'(i_current);
        acc_wide   = (IB+1)'(r_integral) + (IB+1)'(n_last_err);
        // overflow when the two top bits disagree
        if (acc_wide[IB] != acc_wide[IB-1]) begin
            n_integral = acc_wide[IB] ? IMIN : IMAX;
        end else begin
            n_integral = acc_wide[IB-1:0];
        end
        n_deriv = (EW+1)'(n_last_err) - (EW+1)'(r_last_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_integral <= '0;
        end else if (i_load) begin
            r_last_err <= n_last_err;
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_deriv <= n_deriv;
        end
    end

    assign o_err      = r_last_err;
    assign o_integral = r_integral;
    assign o_deriv    = r_deriv;

endmodule

// File: hdl/tapsd_axis_drive.sv
// ----------------------------------------------------------------------------
// tapsd_axis_drive
// Gain products, sum, tilt magnitude clamp and servo pair selection.
// ----------------------------------------------------------------------------
module tapsd_axis_drive
    import tapsd_pkg::*;
#(
    parameter int INTEGRAL_BITS  = INTEGRAL_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  t_gains                            i_gains,
    input  logic signed [POSITION_BITS:0]     i_err,
    input  logic signed [INTEGRAL_BITS-1:0]   i_integral,
    input  logic signed [POSITION_BITS+1:0]   i_deriv,
    output logic [SERVO_BITS-1:0]             o_servo_pos,
    output logic [SERVO_BITS-1:0]             o_servo_neg
);

    localparam int EW = POSITION_BITS + 1;
    localparam int IB = INTEGRAL_BITS;
    localparam int GW = GAIN_BITS + 1;
    // headroom: integral term dominates, plus carry for three addends
    localparam int SW = GW + IB + 2;

    logic signed [GW+EW-1:0]   pterm;
    logic signed [GW+IB-1:0]   iterm;
    logic signed [GW+EW:0]     dterm;
    logic signed [SW-1:0]      sum;
    logic [SW-1:0]             mag;
    logic [SW-1:0]             shifted;
    logic [TILT_BITS-1:0]      tilt;
    logic [SERVO_BITS-1:0]     driven;
    logic                      pos_side;

    always_comb begin
        pterm = $signed({1'b0, i_gains.prop_gain})  * i_err;
        iterm = $signed({1'b0, i_gains.integ_gain}) * i_integral;
        dterm = $signed({1'b0, i_gains.deriv_gain}) * i_deriv;
        sum   = SW'(pterm) + SW'(iterm) + SW'(dterm);
        mag   = sum[SW-1] ? SW'(-sum) : SW'(sum);
        shifted = mag >> GAIN_FRAC_BITS;
        tilt  = (shifted > SW'(TILT_MAX)) ? TILT_MAX : shifted[TILT_BITS-1:0];
        driven = SERVO_CENTER + SERVO_BITS'(tilt);
        // zero sum goes to the negative side
        pos_side = !sum[SW-1] && (sum != '0);
        o_servo_pos = pos_side ? driven : SERVO_CENTER;
        o_servo_neg = pos_side ? SERVO_CENTER : driven;
    end

endmodule

// File: hdl/two_axis_pid_servo_drive.sv
// ----------------------------------------------------------------------------
// two_axis_pid_servo_drive
// Two-axis PID controller driving left/right and up/down servo pairs.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled. The accepting edge
// loads each axis error, the saturating integrator and the derivative; the
// integrator feedback through its register is the loop that sets the rate.
// The result register is then loaded, when the output is not stalled, from
// the sum of the three Q8.8 gain products with the tilt clamped to 0..45
// degrees. With the output stalled the block holds two items before it drops
// input ready. Gains are to be written through the config port only while no
// item is in flight; the block itself does not enforce this.
module two_axis_pid_servo_drive
    import tapsd_pkg::*;
#(
    parameter int INTEGRAL_BITS  = INTEGRAL_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [GAIN_BITS-1:0]     i_cfg_data
);

`include "two_axis_pid_servo_drive_defines.svh"

    t_gains    r_gains;
    logic      r_s1_valid, n_s1_valid;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      advance;
    logic      load;

    logic signed [POSITION_BITS:0]   err_x, err_y;
    logic signed [INTEGRAL_BITS-1:0] integ_x, integ_y;
    logic signed [POSITION_BITS+1:0] deriv_x, deriv_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop_gain  <= PROP_GAIN_RST;
            r_gains.integ_gain <= INTEG_GAIN_RST;
            r_gains.deriv_gain <= DERIV_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROP_GAIN:  r_gains.prop_gain  <= i_cfg_data;
                CFG_INTEG_GAIN: r_gains.integ_gain <= i_cfg_data;
                CFG_DERIV_GAIN: r_gains.deriv_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result register moves whenever it is empty or being taken
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign load       = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = r_s1_valid;
            n_s1_valid  = 1'b0;
        end
        if (load) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    tapsd_axis_state #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_state_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_current  (i_in_data.current_x),
        .i_desired  (i_in_data.desired_x),
        .o_err      (err_x),
        .o_integral (integ_x),
        .o_deriv    (deriv_x)
    );

    tapsd_axis_state #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_state_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_current  (i_in_data.current_y),
        .i_desired  (i_in_data.desired_y),
        .o_err      (err_y),
        .o_integral (integ_y),
        .o_deriv    (deriv_y)
    );

    tapsd_axis_drive #(
        .INTEGRAL_BITS  (INTEGRAL_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive_x (
        .i_gains     (r_gains),
        .i_err       (err_x),
        .i_integral  (integ_x),
        .i_deriv     (deriv_x),
        .o_servo_pos (n_out.servo_left),
        .o_servo_neg (n_out.servo_right)
    );

    tapsd_axis_drive #(
        .INTEGRAL_BITS  (INTEGRAL_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive_y (
        .i_gains     (r_gains),
        .i_err       (err_y),
        .i_integral  (integ_y),
        .i_deriv     (deriv_y),
        .o_servo_pos (n_out.servo_up),
        .o_servo_neg (n_out.servo_down)
    );

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TAPSD_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !r_s1_valid && !r_out_valid, "pipeline not empty after reset")
    `TAPSD_ASSERT(a_full_blocks, i_clk, i_rst_n, r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready, "input taken while pipeline full")
    `TAPSD_ASSERT(a_s1_kept, i_clk, i_rst_n, r_s1_valid && !advance |=> r_s1_valid, "stage item dropped under stall")
    `TAPSD_ASSERT(a_x_parked, i_clk, i_rst_n, o_out_valid |-> o_out_data.servo_left == SERVO_CENTER || o_out_data.servo_right == SERVO_CENTER, "both X servos driven")
    `TAPSD_ASSERT(a_y_parked, i_clk, i_rst_n, o_out_valid |-> o_out_data.servo_up == SERVO_CENTER || o_out_data.servo_down == SERVO_CENTER, "both Y servos driven")

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the two-axis PID servo drive
// Streams position items through the block under random valid/ready pressure,
// predicts each servo result from a local PID model of both axes and checks
// every result in order. Gains are changed between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
    import tapsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int INTEG_W     = INTEGRAL_BITS_DEF;
    localparam int FRAC_W      = GAIN_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 250;
    localparam int SAT_ITEMS   = 100;
    localparam int AXIS_X      = 0;
    localparam int AXIS_Y      = 1;
    // index past the register list, writes to it must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG = 2'd3;

    localparam longint TERM_CAP = 64'sd1 <<< 61;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    t_in_item                i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out_item               o_out_data;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx   = '0;
    logic [GAIN_BITS-1:0]    i_cfg_data  = '0;

    two_axis_pid_servo_drive u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // model state
    logic [GAIN_BITS-1:0]          kp = PROP_GAIN_RST;
    logic [GAIN_BITS-1:0]          ki = INTEG_GAIN_RST;
    logic [GAIN_BITS-1:0]          kd = DERIV_GAIN_RST;
    logic signed [INTEG_W-1:0]     integ_acc [2];
    logic signed [POSITION_BITS:0] prev_err  [2];

    t_in_item  pending_items [$];
    t_out_item servo_expect  [$];

    int  idle_pct   = 0;
    int  gap_left   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    int  hold_arm   = 0;
    int  hold_seen  = 0;
    int  mismatches = 0;
    int  cycle_cnt  = 0;
    bit  in_took    = 1'b0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one axis update, returns the Q8.8 sum
    function automatic longint axis_update(int ax, longint cur, longint des);
        longint err, acc, der, iterm;
        longint imax, imin;
        imax = (64'sd1 <<< (INTEG_W - 1)) - 1;
        imin = -imax - 1;
        err  = des - cur;
        acc  = longint'(integ_acc[ax]) + err;
        der  = err - longint'(prev_err[ax]);
        if (acc > imax) acc = imax;
        if (acc < imin) acc = imin;
        integ_acc[ax] = acc[INTEG_W-1:0];
        prev_err[ax]  = err[POSITION_BITS:0];
        iterm = longint'(ki) * acc;
        if (iterm > TERM_CAP) iterm = TERM_CAP;
        if (iterm < -TERM_CAP) iterm = -TERM_CAP;
        return longint'(kp) * err + iterm + longint'(kd) * der;
    endfunction

    // {positive-side servo, negative-side servo}
    function automatic logic [2*SERVO_BITS-1:0] servo_pair(longint sum);
        longint                mag;
        logic [TILT_BITS-1:0]  tilt;
        logic [SERVO_BITS-1:0] drv;
        mag = (sum < 0) ? -sum : sum;
        mag = mag >> FRAC_W;
        tilt = (mag > longint'(TILT_MAX)) ? TILT_MAX : mag[TILT_BITS-1:0];
        drv  = SERVO_CENTER + SERVO_BITS'(tilt);
        // zero sum counts as the negative side
        return (sum > 0) ? {drv, SERVO_CENTER} : {SERVO_CENTER, drv};
    endfunction

    function automatic t_out_item predict_servos(t_in_item it);
        t_out_item res;
        longint    sx, sy;
        sx = axis_update(AXIS_X, longint'(it.current_x), longint'(it.desired_x));
        sy = axis_update(AXIS_Y, longint'(it.current_y), longint'(it.desired_y));
        {res.servo_left, res.servo_right} = servo_pair(sx);
        {res.servo_up, res.servo_down}    = servo_pair(sy);
        return res;
    endfunction

    function automatic logic [POSITION_BITS-1:0] pick_pos(int mode);
        logic [POSITION_BITS-1:0] edges [5] = '{16'h8000, 16'hFFFF, 16'h0000,
                                                16'h0001, 16'h7FFF};
        if (mode == 0) return POSITION_BITS'($urandom);
        return edges[$urandom_range(4)];
    endfunction

    // mostly near-target tracking, some full-range noise and some extremes
    function automatic t_in_item make_item();
        t_in_item it;
        int       sel;
        sel = $urandom_range(9);
        if (sel < 5) begin
            it.current_x = POSITION_BITS'($urandom);
            it.current_y = POSITION_BITS'($urandom);
            it.desired_x = it.current_x + POSITION_BITS'($urandom_range(600) - 300);
            it.desired_y = it.current_y + POSITION_BITS'($urandom_range(600) - 300);
        end else begin
            it.current_x = pick_pos(sel < 8 ? 0 : 1);
            it.current_y = pick_pos(sel < 8 ? 0 : 1);
            it.desired_x = pick_pos(sel < 8 ? 0 : 1);
            it.desired_y = pick_pos(sel < 8 ? 0 : 1);
        end
        return it;
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0 && $urandom_range(99) < idle_pct) begin
                gap_left   <= $urandom_range(6);
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_arm) begin
            hold_seen   <= hold_arm;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
            stall_left  <= $urandom_range(6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: gain writes, predictions and result checks
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && o_in_ready;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:  kp = i_cfg_data;
                    CFG_INTEG_GAIN: ki = i_cfg_data;
                    CFG_DERIV_GAIN: kd = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                servo_expect.push_back(predict_servos(i_in_data));
            if (o_out_valid && i_out_ready) begin
                if (servo_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with nothing pending: %h", $realtime,
                                 o_out_data);
                end else begin
                    want = servo_expect.pop_front();
                    if (o_out_data.servo_left  !== want.servo_left  ||
                        o_out_data.servo_right !== want.servo_right ||
                        o_out_data.servo_up    !== want.servo_up    ||
                        o_out_data.servo_down  !== want.servo_down) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] servo mismatch L/R/U/D exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     $realtime, want.servo_left, want.servo_right,
                                     want.servo_up, want.servo_down,
                                     o_out_data.servo_left, o_out_data.servo_right,
                                     o_out_data.servo_up, o_out_data.servo_down);
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || servo_expect.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_gain(logic [CFG_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_gains(logic [GAIN_BITS-1:0] p, logic [GAIN_BITS-1:0] i,
                             logic [GAIN_BITS-1:0] d);
        write_gain(CFG_PROP_GAIN, p);
        write_gain(CFG_INTEG_GAIN, i);
        write_gain(CFG_DERIV_GAIN, d);
    endtask

    task automatic run_random(int n, int pct);
        idle_pct = pct;
        repeat (n) pending_items.push_back(make_item());
        wait_idle();
    endtask

    task automatic push_pos(logic [POSITION_BITS-1:0] cx, logic [POSITION_BITS-1:0] dx,
                            logic [POSITION_BITS-1:0] cy, logic [POSITION_BITS-1:0] dy);
        t_in_item it;
        it.current_x = cx;
        it.desired_x = dx;
        it.current_y = cy;
        it.desired_y = dy;
        pending_items.push_back(it);
    endtask

    initial begin
        integ_acc = '{default: '0};
        prev_err  = '{default: '0};
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items on reset gains
        idle_pct = 20;
        push_pos(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero sum, all centered
        push_pos(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);  // largest errors
        push_pos(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);  // same again, no derivative
        push_pos(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        push_pos(16'h0000, 16'h0001, 16'h0001, 16'h0000);
        push_pos(16'h1234, 16'h1234, 16'hFFFF, 16'hFFFF);  // error zero, integral left
        push_pos(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        push_pos(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        push_pos(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_pos(16'h0010, 16'h0000, 16'h0000, 16'h0010);
        push_pos(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        wait_idle();

        // long receiver hold while the sender keeps offering items
        set_gains(16'd512, 16'd40, 16'd100);
        hold_arm++;
        run_random(400, 25);

        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(300, 15);

        set_gains(16'h0000, 16'h0000, 16'h0000);
        write_gain(CFG_NO_REG, 16'h0200);
        run_random(100, 30);

        set_gains(16'd1, 16'd0, 16'd0);
        run_random(300, 10);

        // ramp the x integral far up and the y integral far down
        set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST);
        idle_pct = 0;
        repeat (SAT_ITEMS) push_pos(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        wait_idle();
        set_gains(16'd3, 16'hFFFF, 16'd7);
        run_random(100, 20);

        set_gains(16'($urandom), 16'($urandom), 16'($urandom));
        run_random(300, 20);

        // final stretch without idling
        set_gains(16'($urandom_range(1024)), 16'($urandom_range(64)),
                  16'($urandom_range(256)));
        run_random(350, 0);

        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && servo_expect.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tapsd_pkg.sv
hdl/tapsd_axis_state.sv
hdl/tapsd_axis_drive.sv
hdl/two_axis_pid_servo_drive.sv
sim/testbench.sv
